// ===== rtl/core/vdi_pkg.sv =====
// shared types and constants for the vertex deduplication index block
package vdi_pkg;

  localparam int WORD_W    = 32;
  localparam int KEY_W     = 8 * WORD_W;
  localparam int OUT_IDX_W = 10;

  // compare chain geometry
  localparam int NUM_CELLS = 8;
  localparam int CELL_BITS = 3;
  localparam int CELL_LAT  = 2;
  localparam int CHAIN_LAT = CELL_LAT * NUM_CELLS;
  localparam int DRAIN_W   = $clog2(CHAIN_LAT);

  typedef logic [KEY_W-1:0]     key_t;
  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [OUT_IDX_W-1:0] out_idx_t;

endpackage

// ===== rtl/core/vdi_in_if.sv =====
// input channel: one expanded vertex per transaction
interface vdi_in_if;
  logic               valid;
  logic               ready;
  logic               start_model;
  vdi_pkg::word_t     pos_x;
  vdi_pkg::word_t     pos_y;
  vdi_pkg::word_t     pos_z;
  vdi_pkg::word_t     tex_u;
  vdi_pkg::word_t     tex_v;
  vdi_pkg::word_t     norm_x;
  vdi_pkg::word_t     norm_y;
  vdi_pkg::word_t     norm_z;

  modport source (
    output valid, start_model, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
    input  ready
  );

  modport sink (
    input  valid, start_model, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
    output ready
  );
endinterface

// ===== rtl/core/vdi_out_if.sv =====
// result channel: one index result per transaction
interface vdi_out_if;
  logic                valid;
  logic                ready;
  vdi_pkg::out_idx_t   element_index;
  logic                is_new;
  logic                table_full;

  modport source (
    output valid, element_index, is_new, table_full,
    input  ready
  );

  modport sink (
    input  valid, element_index, is_new, table_full,
    output ready
  );
endinterface

// ===== rtl/core/vertex_dedup_index.sv =====
// top level of the vertex deduplication index block
//
// Usage: each input transaction on in_ch carries one expanded vertex (eight
// raw 32-bit words) and a start_model flag that empties the table first.
// Each accepted vertex gives exactly one result on out_ch: the index of the
// matching stored key, or the index it was appended at (is_new set), or
// table_full set with index 0 when the key is new and no entry is free.
// The keys live in a chain of eight compare cells; entry n sits in cell
// n mod 8 at row n / 8. A probe sends one token per occupied row down the
// chain, each cell checking its bank and passing the token on.
// The time from acceptance to the result register grows with count, the
// entries stored before that vertex, and is set by the row scan and the
// chain traversal. One vertex is worked on at a time; the next one can be
// accepted in the cycle after the result is loaded, even while that result
// still waits for out_ch.ready.
// Reset empties the table and clears all valids. While the receiver
// stalls, the result is held; a following vertex may be searched but its
// result waits until the held one is taken.
module vertex_dedup_index #(
  parameter int CAPACITY = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  vdi_in_if.sink    in_ch,
  vdi_out_if.source out_ch
);
  import vdi_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DEPTH  = (CAPACITY + NUM_CELLS - 1) / NUM_CELLS;
  localparam int ROW_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ADDR_W = ROW_W + CELL_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  key_t                key_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_eff;
  logic [ADDR_W-1:0]   last_addr;
  logic [ROW_W-1:0]    last_row_r;
  logic [ROW_W-1:0]    scan_row_r;
  logic [DRAIN_W-1:0]  drain_cnt_r;
  logic                found_r;
  logic [ADDR_W-1:0]   found_idx_r;
  logic                out_valid_r;
  out_idx_t            out_idx_r;
  logic                out_new_r;
  logic                out_full_r;
  logic                in_fire;
  logic                done_fire;
  logic                is_full;
  logic                do_write;
  logic [ADDR_W-1:0]   wr_addr;

  // token links between cells
  logic                tok_valid [NUM_CELLS+1];
  logic [ROW_W-1:0]    tok_row   [NUM_CELLS+1];
  logic                tok_found [NUM_CELLS+1];
  logic [ADDR_W-1:0]   tok_idx   [NUM_CELLS+1];

  // handshakes
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign done_fire   = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // entry count after an optional start and the last row to scan
  assign count_eff = in_ch.start_model ? '0 : count_r;
  assign last_addr = ADDR_W'(count_eff - CNT_W'(1));

  // outcome of the search at the result step
  assign is_full  = (count_r >= CNT_W'(CAPACITY));
  assign do_write = done_fire && !found_r && !is_full;
  assign wr_addr  = ADDR_W'(count_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (count_eff == '0) ? S_DRAIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_row_r == last_row_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_cnt_r == DRAIN_W'(CHAIN_LAT - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // probe key and scan limits, latched on an input transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r      <= {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.tex_u,
                     in_ch.tex_v, in_ch.norm_x, in_ch.norm_y, in_ch.norm_z};
      last_row_r <= last_addr[ADDR_W-1:CELL_BITS];
    end
  end

  // row scan and drain counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_row_r  <= '0;
      drain_cnt_r <= '0;
    end else begin
      if (in_fire) begin
        scan_row_r <= '0;
      end else if (state_r == S_SCAN) begin
        scan_row_r <= scan_row_r + ROW_W'(1);
      end
      if (state_r == S_DRAIN) begin
        drain_cnt_r <= drain_cnt_r + DRAIN_W'(1);
      end else begin
        drain_cnt_r <= '0;
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_fire) begin
      count_r <= count_eff;
    end else if (do_write) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // token injection at the head of the chain
  assign tok_valid[0] = (state_r == S_SCAN);
  assign tok_row[0]   = scan_row_r;
  assign tok_found[0] = 1'b0;
  assign tok_idx[0]   = '0;

  // compare chain
  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    vdi_cell #(
      .CELL_ID (c),
      .DEPTH   (DEPTH),
      .ROW_W   (ROW_W),
      .ADDR_W  (ADDR_W),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (do_write && (wr_addr[CELL_BITS-1:0] == CELL_BITS'(c))),
      .wr_row    (wr_addr[ADDR_W-1:CELL_BITS]),
      .wr_data   (key_r),
      .key       (key_r),
      .count     (count_r),
      .in_valid  (tok_valid[c]),
      .in_row    (tok_row[c]),
      .in_found  (tok_found[c]),
      .in_idx    (tok_idx[c]),
      .out_valid (tok_valid[c+1]),
      .out_row   (tok_row[c+1]),
      .out_found (tok_found[c+1]),
      .out_idx   (tok_idx[c+1])
    );
  end

  // collect the first match leaving the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (in_fire) begin
      found_r <= 1'b0;
    end else if (tok_valid[NUM_CELLS] && tok_found[NUM_CELLS] && !found_r) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_valid[NUM_CELLS] && tok_found[NUM_CELLS] && !found_r) begin
      found_idx_r <= tok_idx[NUM_CELLS];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      priority if (found_r) begin
        out_idx_r  <= OUT_IDX_W'(found_idx_r);
        out_new_r  <= 1'b0;
        out_full_r <= 1'b0;
      end else if (is_full) begin
        out_idx_r  <= '0;
        out_new_r  <= 1'b0;
        out_full_r <= 1'b1;
      end else begin
        out_idx_r  <= OUT_IDX_W'(count_r);
        out_new_r  <= 1'b1;
        out_full_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.element_index = out_idx_r;
  assign out_ch.is_new        = out_new_r;
  assign out_ch.table_full    = out_full_r;

  // tokens only travel while a search is running
  a_tok_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok_valid[NUM_CELLS] |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("token left the chain outside a search");

  // the count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // an appended vertex raises the count by one
  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_write |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("append did not advance the entry count");

  // a new result is loaded only by the result step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !$past(out_ch.valid)) |-> $past(state_r == S_DONE))
    else $error("result appeared without a finished search");

endmodule

// ===== rtl/core/vdi_cell.sv =====
// one compare cell: a bank of stored keys and a two-stage token slot
module vdi_cell #(
  parameter int CELL_ID = 0,
  parameter int DEPTH   = 128,
  parameter int ROW_W   = 7,
  parameter int ADDR_W  = 10,
  parameter int CNT_W   = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  // key bank write port
  input  logic               wr_en,
  input  logic [ROW_W-1:0]   wr_row,
  input  vdi_pkg::key_t      wr_data,
  // probe key and live entry count
  input  vdi_pkg::key_t      key,
  input  logic [CNT_W-1:0]   count,
  // token from the previous cell
  input  logic               in_valid,
  input  logic [ROW_W-1:0]   in_row,
  input  logic               in_found,
  input  logic [ADDR_W-1:0]  in_idx,
  // token to the next cell
  output logic               out_valid,
  output logic [ROW_W-1:0]   out_row,
  output logic               out_found,
  output logic [ADDR_W-1:0]  out_idx
);
  import vdi_pkg::*;

  localparam int CMP_W = (ADDR_W > CNT_W) ? ADDR_W : CNT_W;

  key_t               mem_q [DEPTH];
  key_t               rdata_r;
  logic               a_valid_r;
  logic [ROW_W-1:0]   a_row_r;
  logic               a_found_r;
  logic [ADDR_W-1:0]  a_idx_r;
  logic               o_valid_r;
  logic [ROW_W-1:0]   o_row_r;
  logic               o_found_r;
  logic [ADDR_W-1:0]  o_idx_r;
  logic [ADDR_W-1:0]  entry_addr;
  logic               entry_live;
  logic               hit;

  // key bank, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_row] <= wr_data;
    end
    rdata_r <= mem_q[in_row];
  end

  // first slot: wait for the bank read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
    end
    a_row_r   <= in_row;
    a_found_r <= in_found;
    a_idx_r   <= in_idx;
  end

  // entry address of this slot and whether it lies below the count
  assign entry_addr = {a_row_r, CELL_BITS'(CELL_ID)};
  assign entry_live = CMP_W'(entry_addr) < CMP_W'(count);
  assign hit        = a_valid_r && !a_found_r && entry_live && (rdata_r == key);

  // second slot: merge this cell's match into the token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= a_valid_r;
    end
    o_row_r   <= a_row_r;
    o_found_r <= a_found_r | hit;
    o_idx_r   <= hit ? entry_addr : a_idx_r;
  end

  assign out_valid = o_valid_r;
  assign out_row   = o_row_r;
  assign out_found = o_found_r;
  assign out_idx   = o_idx_r;

endmodule
